// ----- sv/sync_framed_packet_receiver_assert.svh -----
// Assertion macros shared by the frame receiver RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFPR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

// ----- sv/sfpr_pkg.sv -----
// Package for the framed packet receiver: phase type, result kind codes,
// configuration indexes, reset values and the byte-wide CRC-32 update.
// No dependencies.
package sfpr_pkg;

    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 32;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CRC_W-1:0]  CRC_SEED = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 32'hEDB8_8320;
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;

    typedef enum logic [2:0] {
        PH_SYNC0 = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRC   = 3'd5
    } phase_t;

    // Reflected CRC-32 over one byte, eight shift steps.
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int i = 0; i < BYTE_W; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- sv/sync_framed_packet_receiver.sv -----
// Framed packet receiver: sync hunt, id, length, payload and CRC-32 check.
// Depends on sfpr_pkg and sync_framed_packet_receiver_assert.svh.
//
//   channel   direction  ports                         handshake
//   s_        in         s_rx_byte                     s_valid / s_ready
//   m_        out        m_kind .. m_crc_seen          m_valid / m_ready
//   cfg_      in         cfg_index, cfg_wdata          cfg_we, no wait
//
// Every byte is handled in the cycle it is accepted; one per cycle unless stalled.
// A payload byte or verdict lands in the output register in the cycle after acceptance.
// The output register is the only stall point: input is taken while it is empty
// or being drained in the same cycle.
// Reset (aresetn low, synchronous) returns to the sync hunt and restores sync bytes.
`include "sync_framed_packet_receiver_assert.svh"

module sync_framed_packet_receiver
    import sfpr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_rx_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_kind,
    output logic [BYTE_W-1:0]      m_msg_id,
    output logic [BYTE_W-1:0]      m_frame_length,
    output logic [BYTE_W-1:0]      m_byte_index,
    output logic [BYTE_W-1:0]      m_data_byte,
    output logic [CRC_W-1:0]       m_crc_seen,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_wdata
);

    logic [BYTE_W-1:0] sync_first_reg, sync_second_reg;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] frame_id_reg, frame_id_next;
    logic [BYTE_W-1:0] decl_len_reg, decl_len_next;
    logic [BYTE_W-1:0] pay_cnt_reg, pay_cnt_next;
    logic [2:0]        crc_cnt_reg, crc_cnt_next;
    logic [CRC_W-1:0]  run_crc_reg, run_crc_next;
    logic [CRC_W-1:0]  rx_crc_reg, rx_crc_next;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0] out_id_reg, out_len_reg, out_idx_reg, out_idx_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic [CRC_W-1:0]  out_crc_reg, out_crc_next;

    logic             accept;
    logic             emit;
    logic [CRC_W-1:0] crc_upd;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign crc_upd = crc32_byte((phase_reg == PH_ID) ? CRC_SEED : run_crc_reg, s_rx_byte);

    always_comb begin
        phase_next    = phase_reg;
        frame_id_next = frame_id_reg;
        decl_len_next = decl_len_reg;
        pay_cnt_next  = pay_cnt_reg;
        crc_cnt_next  = crc_cnt_reg;
        run_crc_next  = run_crc_reg;
        rx_crc_next   = rx_crc_reg;
        emit          = 1'b0;
        out_kind_next = KIND_PAYLOAD;
        out_idx_next  = '0;
        out_data_next = '0;
        out_crc_next  = '0;
        case (phase_reg)
            PH_SYNC1: begin
                // A match on the second sync byte wins when both sync values are equal.
                if (s_rx_byte == sync_second_reg) begin
                    phase_next = PH_ID;
                end else if (s_rx_byte != sync_first_reg) begin
                    phase_next = PH_SYNC0;
                end
            end
            PH_ID: begin
                frame_id_next = s_rx_byte;
                run_crc_next  = crc_upd;
                phase_next    = PH_LEN;
            end
            PH_LEN: begin
                decl_len_next = s_rx_byte;
                pay_cnt_next  = '0;
                crc_cnt_next  = '0;
                rx_crc_next   = '0;
                run_crc_next  = crc_upd;
                phase_next    = (s_rx_byte == '0) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
                emit          = 1'b1;
                out_idx_next  = pay_cnt_reg;
                out_data_next = s_rx_byte;
                run_crc_next  = crc_upd;
                pay_cnt_next  = pay_cnt_reg + 8'd1;
                if (pay_cnt_next >= decl_len_reg) begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC: begin
                // CRC bytes arrive least significant first.
                rx_crc_next  = rx_crc_reg
                             | ({24'd0, s_rx_byte} << {crc_cnt_reg[1:0], 3'b000});
                crc_cnt_next = crc_cnt_reg + 3'd1;
                if (crc_cnt_next >= 3'd4) begin
                    emit          = 1'b1;
                    out_kind_next = (rx_crc_next == run_crc_reg) ? KIND_GOOD : KIND_BAD;
                    out_crc_next  = run_crc_reg;
                    phase_next    = PH_SYNC0;
                end
            end
            default: begin
                phase_next = (s_rx_byte == sync_first_reg) ? PH_SYNC1 : PH_SYNC0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC0;
            frame_id_reg <= '0;
            decl_len_reg <= '0;
            pay_cnt_reg  <= '0;
            crc_cnt_reg  <= '0;
            run_crc_reg  <= CRC_SEED;
            rx_crc_reg   <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            frame_id_reg <= frame_id_next;
            decl_len_reg <= decl_len_next;
            pay_cnt_reg  <= pay_cnt_next;
            crc_cnt_reg  <= crc_cnt_next;
            run_crc_reg  <= run_crc_next;
            rx_crc_reg   <= rx_crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            out_kind_reg <= out_kind_next;
            out_id_reg   <= frame_id_reg;
            out_len_reg  <= decl_len_reg;
            out_idx_reg  <= out_idx_next;
            out_data_reg <= out_data_next;
            out_crc_reg  <= out_crc_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_kind_reg;
    assign m_msg_id       = out_id_reg;
    assign m_frame_length = out_len_reg;
    assign m_byte_index   = out_idx_reg;
    assign m_data_byte    = out_data_reg;
    assign m_crc_seen     = out_crc_reg;

    `SFPR_ASSERT_NEXT(a_emit_loads_output, aclk, aresetn, accept && emit, m_valid)
    `SFPR_ASSERT_SAME(a_crc_count_range, aclk, aresetn, phase_reg == PH_CRC,
                      crc_cnt_reg <= 3'd3)
    `SFPR_ASSERT_SAME(a_verdict_fields, aclk, aresetn,
                      m_valid && (m_kind != KIND_PAYLOAD),
                      (m_byte_index == '0) && (m_data_byte == '0))
    `SFPR_ASSERT_SAME(a_payload_in_range, aclk, aresetn,
                      m_valid && (m_kind == KIND_PAYLOAD),
                      (m_byte_index < m_frame_length) && (m_crc_seen == '0))

endmodule

// ----- verif/sync_framed_packet_receiver_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sync_framed_packet_receiver: framed byte traffic with
// random idle gaps on both handshakes, checked against a cycle-free frame predictor.
// Depends on sfpr_pkg and the sync_framed_packet_receiver RTL.
module sync_framed_packet_receiver_tb;
    import sfpr_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] msg_id;
        logic [BYTE_W-1:0] frame_length;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] data_byte;
        logic [CRC_W-1:0]  crc_seen;
    } rx_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_rx_byte;
    logic                   m_valid;
    logic                   m_ready;
    logic [KIND_W-1:0]      m_kind;
    logic [BYTE_W-1:0]      m_msg_id;
    logic [BYTE_W-1:0]      m_frame_length;
    logic [BYTE_W-1:0]      m_byte_index;
    logic [BYTE_W-1:0]      m_data_byte;
    logic [CRC_W-1:0]       m_crc_seen;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]      cfg_wdata;

    // Frame predictor state, advanced once per accepted input transaction.
    phase_t            frame_phase;
    logic [BYTE_W-1:0] frame_id;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] frame_count;
    logic [2:0]        frame_crc_cnt;
    logic [CRC_W-1:0]  frame_crc;
    logic [CRC_W-1:0]  frame_rx_crc;
    logic [BYTE_W-1:0] model_sync_first;
    logic [BYTE_W-1:0] model_sync_second;

    // Sync bytes the sender frames with; follows the register writes it issues.
    logic [BYTE_W-1:0] tx_sync_first;
    logic [BYTE_W-1:0] tx_sync_second;

    rx_result_t pending_results[$];
    int         mismatches;
    int         idle_cycles;
    int         bytes_sent;
    int         frames_sent;
    int         good_frames;
    int         bad_frames;
    int         payload_seen;
    int         settings_used;
    bit         no_gaps;

    sync_framed_packet_receiver DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_msg_id       (m_msg_id),
        .m_frame_length (m_frame_length),
        .m_byte_index   (m_byte_index),
        .m_data_byte    (m_data_byte),
        .m_crc_seen     (m_crc_seen),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [CRC_W-1:0] crc32_step(input logic [CRC_W-1:0] c,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] acc;
        acc = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        repeat (BYTE_W) acc = (acc >> 1) ^ (CRC_POLY & {CRC_W{acc[0]}});
        return acc;
    endfunction

    function automatic void predict_byte(input logic [BYTE_W-1:0] b);
        rx_result_t r;
        case (frame_phase)
            PH_SYNC1: begin
                // The second sync byte wins when both sync values are equal.
                if (b == model_sync_second) begin
                    frame_phase = PH_ID;
                end else if (b != model_sync_first) begin
                    frame_phase = PH_SYNC0;
                end
            end
            PH_ID: begin
                frame_id    = b;
                frame_crc   = crc32_step(CRC_SEED, b);
                frame_phase = PH_LEN;
            end
            PH_LEN: begin
                frame_len     = b;
                frame_count   = '0;
                frame_crc_cnt = '0;
                frame_rx_crc  = '0;
                frame_crc     = crc32_step(frame_crc, b);
                frame_phase   = (b == 0) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
                r = '{KIND_PAYLOAD, frame_id, frame_len, frame_count, b, '0};
                pending_results.push_back(r);
                frame_crc   = crc32_step(frame_crc, b);
                frame_count = frame_count + 1'b1;
                if (frame_count >= frame_len) begin
                    frame_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                frame_rx_crc  = frame_rx_crc |
                                ({{(CRC_W-BYTE_W){1'b0}}, b} << (8 * frame_crc_cnt[1:0]));
                frame_crc_cnt = frame_crc_cnt + 1'b1;
                if (frame_crc_cnt >= 3'd4) begin
                    r = '{(frame_rx_crc == frame_crc) ? KIND_GOOD : KIND_BAD,
                          frame_id, frame_len, '0, '0, frame_crc};
                    pending_results.push_back(r);
                    frame_phase = PH_SYNC0;
                end
            end
            default: begin
                frame_phase = (b == model_sync_first) ? PH_SYNC1 : PH_SYNC0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [CRC_W-1:0] want,
                                        input logic [CRC_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return BYTE_W'($urandom_range(0, 4));
        if (r < 95) return BYTE_W'($urandom_range(5, 20));
        return BYTE_W'($urandom_range(21, 255));
    endfunction

    // Line noise never holds the first sync byte, so the hunt stays in place.
    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        while (b == tx_sync_first) b = BYTE_W'($urandom_range(0, 255));
        return b;
    endfunction

    always @(posedge aclk) begin : result_monitor
        rx_result_t want;
        logic       accepted;
        accepted = 1'b0;
        if (aresetn) begin
            // Results come from earlier inputs, so they are checked before predicting.
            if (m_valid && m_ready) begin
                accepted = 1'b1;
                case (m_kind)
                    KIND_PAYLOAD: payload_seen++;
                    KIND_GOOD:    good_frames++;
                    default:      bad_frames++;
                endcase
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual kind %0d id %0h",
                             $time, m_kind, m_msg_id);
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", CRC_W'(want.kind), CRC_W'(m_kind));
                    check_field("msg_id", CRC_W'(want.msg_id), CRC_W'(m_msg_id));
                    check_field("frame_length", CRC_W'(want.frame_length),
                                CRC_W'(m_frame_length));
                    check_field("byte_index", CRC_W'(want.byte_index), CRC_W'(m_byte_index));
                    check_field("data_byte", CRC_W'(want.data_byte), CRC_W'(m_data_byte));
                    check_field("crc_seen", want.crc_seen, m_crc_seen);
                end
            end
            if (s_valid && s_ready) begin
                accepted = 1'b1;
                predict_byte(s_rx_byte);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  model_sync_first  = cfg_wdata;
                    CFG_SYNC_SECOND: model_sync_second = cfg_wdata;
                    default: ;
                endcase
            end
        end
        idle_cycles = accepted ? 0 : idle_cycles + 1;
    end

    initial begin : ready_gen
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (no_gaps || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                hold = pick_gap();
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("sync_framed_packet_receiver_tb failed");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] len,
                              input int fill, input bit bad_crc, input int extra_first);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] data;
        send_byte(tx_sync_first);
        repeat (extra_first) send_byte(tx_sync_first);
        send_byte(tx_sync_second);
        send_byte(id);
        send_byte(len);
        crc = crc32_step(crc32_step(CRC_SEED, id), len);
        for (int i = 0; i < len; i++) begin
            data = (fill < 0) ? BYTE_W'($urandom_range(0, 255)) : fill[BYTE_W-1:0];
            send_byte(data);
            crc = crc32_step(crc, data);
        end
        if (bad_crc) begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        end
        for (int k = 0; k < 4; k++) send_byte(crc[8*k +: 8]);
        frames_sent++;
    endtask

    // Drops valid and waits until every predicted result has been taken.
    task automatic settle_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [BYTE_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SYNC_FIRST) tx_sync_first = value;
        else tx_sync_second = value;
    endtask

    task automatic test_directed_frames();
        // Empty payload with id and length at zero, good CRC.
        send_frame(8'h00, 8'h00, 0, 1'b0, 0);
        // Repeated first sync, then a one-byte frame of all ones with a broken CRC.
        send_frame(8'hFF, 8'h01, 255, 1'b1, 2);
        // First sync followed by a stray byte falls back to the hunt.
        send_byte(tx_sync_first);
        send_byte(8'h13);
    endtask

    task automatic test_longest_frame();
        send_frame(BYTE_W'($urandom_range(0, 255)), 8'hFF, -1, 1'b0, 0);
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int                start;
        int                r;
        int                extra;
        logic [BYTE_W-1:0] x;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 80) begin
                extra = 0;
                if (tx_sync_first != tx_sync_second && $urandom_range(0, 4) == 0) begin
                    extra = $urandom_range(1, 3);
                end
                send_frame(BYTE_W'($urandom_range(0, 255)), pick_len(), -1,
                           $urandom_range(0, 3) == 0, extra);
            end else if (r < 90) begin
                repeat ($urandom_range(1, 6)) send_byte(noise_byte());
            end else begin
                send_byte(tx_sync_first);
                do x = BYTE_W'($urandom_range(0, 255));
                while (x == tx_sync_first || x == tx_sync_second);
                send_byte(x);
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_sync_setting(input logic [BYTE_W-1:0] first,
                                     input logic [BYTE_W-1:0] second, input int n_bytes);
        settle_idle();
        write_reg(CFG_SYNC_FIRST, first);
        write_reg(CFG_SYNC_SECOND, second);
        settings_used++;
        test_random_traffic(n_bytes);
    endtask

    initial begin
        aclk              = 1'b0;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_rx_byte         = '0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_SYNC_FIRST;
        cfg_wdata         = '0;
        no_gaps           = 1'b0;
        mismatches        = 0;
        idle_cycles       = 0;
        bytes_sent        = 0;
        frames_sent       = 0;
        good_frames       = 0;
        bad_frames        = 0;
        payload_seen      = 0;
        settings_used     = 1;
        frame_phase       = PH_SYNC0;
        frame_id          = '0;
        frame_len         = '0;
        frame_count       = '0;
        frame_crc_cnt     = '0;
        frame_crc         = CRC_SEED;
        frame_rx_crc      = '0;
        model_sync_first  = SYNC_FIRST_RESET;
        model_sync_second = SYNC_SECOND_RESET;
        tx_sync_first     = SYNC_FIRST_RESET;
        tx_sync_second    = SYNC_SECOND_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_frames();
        test_longest_frame();
        test_random_traffic(300);
        test_sync_setting(8'h00, 8'hFF, 130);
        test_sync_setting(8'hFF, 8'h00, 130);
        test_sync_setting(8'h7E, 8'h7E, 130);
        test_sync_setting(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 130);

        settle_idle();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived, expected none left, actual %0d",
                     $time, pending_results.size(), pending_results.size());
        end
        $display("Sent %0d bytes in %0d frames under %0d sync settings.",
                 bytes_sent, frames_sent, settings_used);
        $display("Checked %0d payload bytes, %0d good and %0d bad frame verdicts.",
                 payload_seen, good_frames, bad_frames);
        if (mismatches == 0) begin
            $display("sync_framed_packet_receiver_tb passed");
        end else begin
            $display("sync_framed_packet_receiver_tb failed");
        end
        $finish;
    end

endmodule
